@@ sv/dksu_pkg.sv @@
// Package for the debounced key sequence unlock block: key class codes,
// sequence positions, register indexes, reset values and the key classifier.
// No dependencies.
`timescale 1ns / 1ps

package dksu_pkg;

    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_START = 3'd1,
        CLS_ESC   = 3'd2,
        CLS_UP    = 3'd3,
        CLS_DOWN  = 3'd4,
        CLS_OTHER = 3'd5
    } key_class_t;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_TIMEOUT  = 2'd2
    } reg_index_t;

    typedef logic [2:0] seq_pos_t;

    localparam seq_pos_t SEQ_IDLE     = 3'd0;
    localparam seq_pos_t SEQ_ARMED    = 3'd1;
    localparam seq_pos_t SEQ_LAST_ESC = 3'd3;
    localparam seq_pos_t SEQ_FIRST_UP = 3'd4;
    localparam seq_pos_t SEQ_LAST_UP  = 3'd5;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int TIMEOUT_W  = 20;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd80;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 20'd10000;

    // up+down together is start; any other mix is "other"
    function automatic key_class_t classify(
        input logic up,
        input logic down,
        input logic esc,
        input logic enter
    );
        key_class_t cls;
        begin
            if (!up && !down && !esc && !enter)
                cls = CLS_NONE;
            else if (up && down)
                cls = CLS_START;
            else if (esc && !up && !down && !enter)
                cls = CLS_ESC;
            else if (up && !down && !esc && !enter)
                cls = CLS_UP;
            else if (down && !up && !esc && !enter)
                cls = CLS_DOWN;
            else
                cls = CLS_OTHER;
            return cls;
        end
    endfunction

endpackage

@@ sv/debounced_key_sequence_unlock.sv @@
// Channel    | Direction | Signals                                          | Notes
// -----------+-----------+--------------------------------------------------+------------------
// sample in  | in        | in_valid/in_ready, key_up/down/esc/enter, now_ms | one key sample
// result out | out       | out_valid/out_ready, start_seen, unlock,         | one per sample
//            |           | seq_position, stable_class                       |
// config     | in        | cfg_valid/cfg_ready, cfg_index, cfg_data         | always ready
//
// Each sample is captured in the input register and its result is then loaded into the
// result register, which drives out_valid; one sample per cycle is sustained while out_ready
// is high. The input register feeds the classifier/debounce/sequence logic, which updates the
// state and loads the result register in the same cycle.
// A stalled output holds the result register and the input register; in_ready
// drops only when both are full and out_ready is low. Reset (rst_n, async, low)
// clears state and restores register defaults (enable 1, 80 ms, 10000 ms).
//
// Depends on dksu_pkg.
`timescale 1ns / 1ps

module debounced_key_sequence_unlock (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        key_up,
    input  logic        key_down,
    input  logic        key_esc,
    input  logic        key_enter,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        start_seen,
    output logic        unlock,
    output logic [2:0]  seq_position,
    output logic [2:0]  stable_class,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int TW = dksu_pkg::TIME_W;
    localparam int DW = dksu_pkg::DEBOUNCE_W;
    localparam int OW = dksu_pkg::TIMEOUT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic          enable_reg;
    logic [DW-1:0] debounce_reg;
    logic [OW-1:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            debounce_reg <= dksu_pkg::DEBOUNCE_RST;
            timeout_reg  <= dksu_pkg::TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dksu_pkg::reg_index_t'(cfg_index))
                dksu_pkg::REG_ENABLE:   enable_reg   <= cfg_data[0];
                dksu_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data[DW-1:0];
                dksu_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data[OW-1:0];
                default: ; // unused index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;   // result register can take the item in the input register

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Input payload register (no reset needed)
    logic          up_reg, down_reg, esc_reg, enter_reg;
    logic [TW-1:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            up_reg    <= key_up;
            down_reg  <= key_down;
            esc_reg   <= key_esc;
            enter_reg <= key_enter;
            now_reg   <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    dksu_pkg::seq_pos_t   seq_reg, seq_next;
    dksu_pkg::key_class_t last_class_reg, last_class_next;
    dksu_pkg::key_class_t held_class_reg, held_class_next;
    dksu_pkg::key_class_t acted_class_reg, acted_class_next;
    logic [TW-1:0]        change_time_reg, change_time_next;
    logic [TW-1:0]        arm_time_reg, arm_time_next;
    logic                 start_next, unlock_next;

    dksu_pkg::key_class_t cls;
    dksu_pkg::seq_pos_t   seq_live;     // position after the timeout check
    logic [TW-1:0]        since_arm;    // wraps mod 2^32
    logic [TW-1:0]        since_change;
    logic                 timed_out;
    logic                 debounced;

    assign cls          = dksu_pkg::classify(up_reg, down_reg, esc_reg, enter_reg);
    assign since_arm    = now_reg - arm_time_reg;
    assign since_change = now_reg - change_time_reg;
    assign timed_out    = (seq_reg != dksu_pkg::SEQ_IDLE) &&
                          (since_arm >= {{(TW-OW){1'b0}}, timeout_reg});
    assign debounced    = since_change >= {{(TW-DW){1'b0}}, debounce_reg};
    assign seq_live     = timed_out ? dksu_pkg::SEQ_IDLE : seq_reg;

    always_comb
    begin
        seq_next         = seq_reg;
        last_class_next  = last_class_reg;
        held_class_next  = held_class_reg;
        acted_class_next = acted_class_reg;
        change_time_next = change_time_reg;
        arm_time_next    = arm_time_reg;
        start_next       = 1'b0;
        unlock_next      = 1'b0;

        if (enable_reg)
        begin
            seq_next = seq_live;
            if (cls != last_class_reg)
            begin
                // class changed: just restart the hold timer
                last_class_next  = cls;
                change_time_next = now_reg;
            end
            else if (cls == held_class_reg || debounced)
            begin
                held_class_next = cls;
                if (cls == dksu_pkg::CLS_NONE)
                begin
                    acted_class_next = dksu_pkg::CLS_NONE;   // release re-arms keys
                end
                else if (cls != acted_class_reg)
                begin
                    acted_class_next = cls;
                    if (cls == dksu_pkg::CLS_START)
                    begin
                        seq_next      = dksu_pkg::SEQ_ARMED;
                        arm_time_next = now_reg;
                        start_next    = 1'b1;
                    end
                    else if (seq_live >= dksu_pkg::SEQ_ARMED &&
                             seq_live <= dksu_pkg::SEQ_LAST_ESC)
                    begin
                        seq_next = (cls == dksu_pkg::CLS_ESC) ? seq_live + 3'd1
                                                              : dksu_pkg::SEQ_IDLE;
                    end
                    else if (seq_live == dksu_pkg::SEQ_FIRST_UP && cls == dksu_pkg::CLS_UP)
                    begin
                        seq_next = dksu_pkg::SEQ_LAST_UP;
                    end
                    else if (seq_live == dksu_pkg::SEQ_LAST_UP && cls == dksu_pkg::CLS_UP)
                    begin
                        seq_next    = dksu_pkg::SEQ_IDLE;
                        unlock_next = 1'b1;
                    end
                    else
                    begin
                        // wrong key, or an accepted key while idle
                        seq_next = dksu_pkg::SEQ_IDLE;
                    end
                end
            end
        end
    end

    logic step;
    assign step = advance && in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= dksu_pkg::SEQ_IDLE;
            last_class_reg  <= dksu_pkg::CLS_NONE;
            held_class_reg  <= dksu_pkg::CLS_NONE;
            acted_class_reg <= dksu_pkg::CLS_NONE;
            change_time_reg <= '0;
            arm_time_reg    <= '0;
        end
        else if (step)
        begin
            seq_reg         <= seq_next;
            last_class_reg  <= last_class_next;
            held_class_reg  <= held_class_next;
            acted_class_reg <= acted_class_next;
            change_time_reg <= change_time_next;
            arm_time_reg    <= arm_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic     start_reg, unlock_reg;
    logic [2:0] pos_reg, class_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            start_reg  <= start_next;
            unlock_reg <= unlock_next;
            pos_reg    <= seq_next;
            class_reg  <= held_class_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign start_seen   = start_reg;
    assign unlock       = unlock_reg;
    assign seq_position = pos_reg;
    assign stable_class = class_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg <= dksu_pkg::SEQ_LAST_UP)
        else $error("sequence position out of range");

    a_unlock_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unlock |-> seq_position == dksu_pkg::SEQ_IDLE && !start_seen)
        else $error("unlock without return to idle");

    a_start_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_seen |->
            seq_position == dksu_pkg::SEQ_ARMED && stable_class == dksu_pkg::CLS_START)
        else $error("start reported without arming");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(seq_reg) && $stable(held_class_reg) && $stable(arm_time_reg))
        else $error("detector state moved without a sample");

endmodule
